@@ design/pfba_pkg.sv @@
package pfba_pkg;

   localparam int MAX_WORDS  = 1024;
   localparam int WORD_BITS  = 32;
   localparam int PAGE_SHIFT = 12;

   localparam int CAPACITY = MAX_WORDS * WORD_BITS;
   localparam int BIT_W    = $clog2(WORD_BITS);
   localparam int WIDX_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int PG_W     = WIDX_W + BIT_W;
   localparam int CNT_W    = PG_W + 1;

   localparam int CQ_DEPTH = 2;
   localparam int CQ_AW    = $clog2(CQ_DEPTH);
   localparam int RQ_DEPTH = 2;
   localparam int RQ_AW    = $clog2(RQ_DEPTH);

   localparam logic [15:0] TOTAL_PAGES_RST = 16'd32768;

   localparam logic [2:0] OPC_INIT        = 3'd0;
   localparam logic [2:0] OPC_FREE_REGION = 3'd1;
   localparam logic [2:0] OPC_RSV_REGION  = 3'd2;
   localparam logic [2:0] OPC_ALLOC       = 3'd3;
   localparam logic [2:0] OPC_FREE_PAGE   = 3'd4;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NO_FREE,
      STATUS_NOT_ALLOC
   } status_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] region_base;
      logic [31:0] region_size;
      logic [14:0] frame_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [14:0] alloc_frame;
      logic [12:0] bitmap_bytes;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_FILL,
      CMD_FREE_RGN,
      CMD_RSV_RGN,
      CMD_ALLOC,
      CMD_FREE_PAGE
   } cmd_kind_type;

   // page range [lo, stop) for the commands that scan words
   typedef struct packed {
      cmd_kind_type     kind;
      logic             skip;
      logic [PG_W-1:0]  lo;
      logic [CNT_W-1:0] stop;
      logic [12:0]      bytes;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SETUP,
      BK_FILL,
      BK_SCAN,
      BK_ZERO_RD,
      BK_ZERO_WR
   } back_state_type;

endpackage

@@ design/pfba_ram.sv @@
module pfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/pfba_front.sv @@
module pfba_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pfba_pkg::req_type req_data,
   input  logic [15:0]      total_pages,
   input  logic             hold,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output pfba_pkg::cmd_type cmd_data
);
   import pfba_pkg::*;

   cmd_type            cq_mem_ff [CQ_DEPTH];
   logic [CQ_AW-1:0]   cq_wp_ff, cq_wp_in;
   logic [CQ_AW-1:0]   cq_rp_ff, cq_rp_in;
   logic [CQ_AW:0]     cq_cnt_ff, cq_cnt_in;

   cmd_type     cmd_new;
   logic        accept;
   logic [33:0] first_pg, page_cnt, end_pg, end_clip, cap34, frame34, tot34, present;

   assign cap34    = 34'(CAPACITY);
   assign first_pg = 34'(req_data.region_base >> PAGE_SHIFT);
   assign page_cnt = (34'(req_data.region_size) + 34'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
   assign end_pg   = first_pg + page_cnt;
   assign end_clip = (end_pg > cap34) ? cap34 : end_pg;
   assign frame34  = 34'(req_data.frame_index);
   assign tot34    = 34'(total_pages);
   assign present  = (tot34 > cap34) ? cap34 : tot34;

   // classify the request into a back-end command, with its page range for the scans
   always_comb begin
      cmd_new       = '0;
      cmd_new.kind  = CMD_NOP;
      unique case (req_data.opcode) inside
         OPC_INIT: begin
            cmd_new.kind  = CMD_FILL;
            cmd_new.bytes = 13'(((present + 34'(WORD_BITS - 1)) >> BIT_W)
                                * 34'(WORD_BITS / 8));
         end
         OPC_FREE_REGION, OPC_RSV_REGION: begin
            cmd_new.kind = (req_data.opcode == OPC_FREE_REGION) ? CMD_FREE_RGN : CMD_RSV_RGN;
            cmd_new.skip = (first_pg >= end_clip);
            cmd_new.lo   = first_pg[PG_W-1:0];
            cmd_new.stop = end_clip[CNT_W-1:0];
         end
         OPC_ALLOC: begin
            cmd_new.kind = CMD_ALLOC;
            cmd_new.skip = (present == '0);
            cmd_new.stop = present[CNT_W-1:0];
         end
         OPC_FREE_PAGE: begin
            cmd_new.kind = CMD_FREE_PAGE;
            cmd_new.skip = (frame34 >= cap34);
            cmd_new.lo   = frame34[PG_W-1:0];
            cmd_new.stop = CNT_W'(frame34 + 34'd1);
         end
         default: begin
            cmd_new.kind = CMD_NOP;
         end
      endcase
   end

   assign full      = (cq_cnt_ff == (CQ_AW+1)'(CQ_DEPTH)) || hold;
   assign accept    = push && !full;
   assign cmd_valid = (cq_cnt_ff != '0);
   assign cmd_data  = cq_mem_ff[cq_rp_ff];

   always_comb begin
      cq_wp_in  = cq_wp_ff;
      cq_rp_in  = cq_rp_ff;
      cq_cnt_in = cq_cnt_ff;
      if (accept) begin
         cq_wp_in = (cq_wp_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : cq_wp_ff + 1'b1;
      end
      if (cmd_pop) begin
         cq_rp_in = (cq_rp_ff == CQ_AW'(CQ_DEPTH - 1)) ? '0 : cq_rp_ff + 1'b1;
      end
      if (accept && !cmd_pop) begin
         cq_cnt_in = cq_cnt_ff + 1'b1;
      end else if (!accept && cmd_pop) begin
         cq_cnt_in = cq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cq_wp_ff  <= '0;
         cq_rp_ff  <= '0;
         cq_cnt_ff <= '0;
      end else begin
         cq_wp_ff  <= cq_wp_in;
         cq_rp_ff  <= cq_rp_in;
         cq_cnt_ff <= cq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cq_mem_ff[cq_wp_ff] <= cmd_new;
      end
   end

endmodule

@@ design/pfba_back.sv @@
module pfba_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  pfba_pkg::cmd_type cmd_data,
   output logic              clearing,
   output logic              empty,
   input  logic              pop,
   output pfba_pkg::rsp_type rsp_data
);
   import pfba_pkg::*;

   localparam logic [WORD_BITS-1:0] ONES = '1;

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [WIDX_W-1:0]   cnt_ff, cnt_in;
   logic                iss_on_ff, iss_on_in;
   logic [WIDX_W-1:0]   start_ff, start_in;
   logic [WIDX_W-1:0]   last_ff, last_in;
   logic [BIT_W-1:0]    lo_bit_ff, lo_bit_in;
   logic [BIT_W-1:0]    hi_bit_ff, hi_bit_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [WIDX_W-1:0]   chk_word_ff, chk_word_in;

   rsp_type             rq_mem_ff [RQ_DEPTH];
   logic [RQ_AW-1:0]    rq_wp_ff, rq_rp_ff;
   logic [RQ_AW:0]      rq_cnt_ff;

   logic                  wr_en, rd_en;
   logic [WIDX_W-1:0]     wr_addr, rd_addr;
   logic [WORD_BITS-1:0]  wr_data, rd_data;

   logic                  rsp_push, rsp_take, rq_full;
   rsp_type               rsp_in;

   logic [WORD_BITS-1:0]  word_mask, avail;
   logic                  hit, w_first, w_last, sweep_end, is_alloc;
   logic [BIT_W-1:0]      hit_bit;
   logic [PG_W-1:0]       grant;
   logic [CNT_W-1:0]      stop_m1;

   function automatic logic [BIT_W-1:0] low_one(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   pfba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word datapath
   assign w_first   = (chk_word_ff == start_ff);
   assign w_last    = (chk_word_ff == last_ff);
   assign word_mask = (w_first ? (ONES << lo_bit_ff) : ONES)
                    & (w_last ? (ONES >> (BIT_W'(WORD_BITS - 1) - hi_bit_ff)) : ONES);
   assign avail     = ~rd_data & word_mask;
   assign hit       = |avail;
   assign hit_bit   = low_one(avail);
   assign grant     = {chk_word_ff, hit_bit};
   assign sweep_end = (cnt_ff == WIDX_W'(MAX_WORDS - 1));
   assign is_alloc  = (cmd_ff.kind == CMD_ALLOC);
   assign stop_m1   = cmd_ff.stop - 1'b1;
   assign rq_full   = (rq_cnt_ff == (RQ_AW+1)'(RQ_DEPTH));
   assign rsp_take  = pop && !empty;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (sweep_end) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (cmd_valid && !rq_full) state_in = BK_SETUP;
         end
         BK_SETUP: begin
            unique case (cmd_ff.kind) inside
               CMD_FILL:     state_in = BK_FILL;
               CMD_FREE_RGN: state_in = cmd_ff.skip ? BK_ZERO_RD : BK_SCAN;
               CMD_RSV_RGN, CMD_ALLOC, CMD_FREE_PAGE: begin
                  state_in = cmd_ff.skip ? BK_IDLE : BK_SCAN;
               end
               default:      state_in = BK_IDLE;
            endcase
         end
         BK_FILL: begin
            if (sweep_end) state_in = BK_IDLE;
         end
         BK_SCAN: begin
            if (chk_vld_ff) begin
               if (is_alloc && hit) begin
                  state_in = BK_IDLE;
               end else if (w_last) begin
                  state_in = (cmd_ff.kind == CMD_FREE_RGN) ? BK_ZERO_RD : BK_IDLE;
               end
            end
         end
         BK_ZERO_RD: state_in = BK_ZERO_WR;
         BK_ZERO_WR: state_in = BK_IDLE;
         default:    state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cmd_pop  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = cnt_ff;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff;
      wr_data  = ONES;
      rsp_push = 1'b0;
      rsp_in   = '0;
      rsp_in.status = STATUS_OK;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en = 1'b1;
         end
         BK_IDLE: begin
            cmd_pop = cmd_valid && !rq_full;
         end
         BK_SETUP: begin
            if (cmd_ff.kind == CMD_NOP) begin
               rsp_push = 1'b1;
            end else if (cmd_ff.skip && cmd_ff.kind != CMD_FREE_RGN
                         && cmd_ff.kind != CMD_FILL) begin
               rsp_push = 1'b1;
               if (is_alloc) rsp_in.status = STATUS_NO_FREE;
            end
         end
         BK_FILL: begin
            wr_en = 1'b1;
            if (sweep_end) begin
               rsp_push            = 1'b1;
               rsp_in.bitmap_bytes = cmd_ff.bytes;
            end
         end
         BK_SCAN: begin
            rd_en   = iss_on_ff;
            wr_addr = chk_word_ff;
            case (cmd_ff.kind) inside
               CMD_FREE_RGN, CMD_FREE_PAGE: wr_data = rd_data & ~word_mask;
               CMD_ALLOC:                   wr_data = rd_data | (WORD_BITS'(1) << hit_bit);
               default:                     wr_data = rd_data | word_mask;
            endcase
            if (chk_vld_ff) begin
               wr_en = !is_alloc || hit;
               if (is_alloc) begin
                  if (hit) begin
                     rsp_push           = 1'b1;
                     rsp_in.alloc_frame = 15'(grant);
                  end else if (w_last) begin
                     rsp_push      = 1'b1;
                     rsp_in.status = STATUS_NO_FREE;
                  end
               end else if (w_last && cmd_ff.kind != CMD_FREE_RGN) begin
                  rsp_push = 1'b1;
                  // a free page whose bit was already clear
                  if (cmd_ff.kind == CMD_FREE_PAGE && hit) rsp_in.status = STATUS_NOT_ALLOC;
               end
            end
         end
         BK_ZERO_RD: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         BK_ZERO_WR: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = rd_data | WORD_BITS'(1);
            rsp_push = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // counters and per-command setup
   always_comb begin
      cmd_in      = cmd_ff;
      cnt_in      = cnt_ff;
      iss_on_in   = 1'b0;
      start_in    = start_ff;
      last_in     = last_ff;
      lo_bit_in   = lo_bit_ff;
      hi_bit_in   = hi_bit_ff;
      chk_vld_in  = 1'b0;
      chk_word_in = cnt_ff;
      if (cmd_pop) begin
         cmd_in = cmd_data;
      end
      unique case (state_ff) inside
         BK_CLEAR, BK_FILL: begin
            cnt_in = cnt_ff + 1'b1;
         end
         BK_SETUP: begin
            start_in  = cmd_ff.lo[PG_W-1:BIT_W];
            last_in   = stop_m1[PG_W-1:BIT_W];
            lo_bit_in = cmd_ff.lo[BIT_W-1:0];
            hi_bit_in = stop_m1[BIT_W-1:0];
            iss_on_in = 1'b1;
            cnt_in    = (cmd_ff.kind == CMD_FILL) ? '0 : cmd_ff.lo[PG_W-1:BIT_W];
         end
         BK_SCAN: begin
            // reads run one word ahead of the modify and write
            if (iss_on_ff) begin
               cnt_in    = cnt_ff + 1'b1;
               iss_on_in = (cnt_ff != last_ff);
            end
            chk_vld_in = iss_on_ff && (state_in == BK_SCAN);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         cnt_ff     <= '0;
         iss_on_ff  <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         iss_on_ff  <= iss_on_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      start_ff    <= start_in;
      last_ff     <= last_in;
      lo_bit_ff   <= lo_bit_in;
      hi_bit_ff   <= hi_bit_in;
      chk_word_ff <= chk_word_in;
   end

   // result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wp_ff  <= '0;
         rq_rp_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         if (rsp_push) begin
            rq_wp_ff <= (rq_wp_ff == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_wp_ff + 1'b1;
         end
         if (rsp_take) begin
            rq_rp_ff <= (rq_rp_ff == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_rp_ff + 1'b1;
         end
         if (rsp_push && !rsp_take) begin
            rq_cnt_ff <= rq_cnt_ff + 1'b1;
         end else if (!rsp_push && rsp_take) begin
            rq_cnt_ff <= rq_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_mem_ff[rq_wp_ff] <= rsp_in;
      end
   end

   assign empty    = (rq_cnt_ff == '0);
   assign rsp_data = rq_mem_ff[rq_rp_ff];
   assign clearing = (state_ff == BK_CLEAR);

   assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("bitmap read and write hit the same word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rq_full)
      else $error("result pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == BK_SETUP))
      else $error("command taken without setup");

   assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == BK_SCAN))
      else $error("word check outside of a scan");

endmodule

@@ design/page_frame_bitmap_allocator_top.sv @@
// each command is taken in idle and set up, then run: init fills every bitmap word, a region
// walk reads and rewrites each word of its region (free then also sets bit 0 of word 0, the
// page 0 fix), allocate scans words up to the first free page, a single page free rewrites
// one word and an unused code answers at setup. One command at a time is in the sequencer.
// reset: synchronous; a pass then sets all MAX_WORDS bitmap words used, full stays high.
module page_frame_bitmap_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  pfba_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output pfba_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);
   import pfba_pkg::*;

   logic [15:0] total_pages_ff;
   logic        cmd_valid, cmd_pop, clearing;
   cmd_type     cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_pages_ff <= TOTAL_PAGES_RST;
      end else if (csr_wr_en) begin
         total_pages_ff <= csr_wr_data;
      end
   end

   pfba_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .total_pages (total_pages_ff),
      .hold        (clearing),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data)
   );

   pfba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .clearing  (clearing),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
